// ===== rtl/itp_pkg.sv =====
// Shared types, character codes and classification helpers for the
// infix-to-postfix converter. No dependencies.
`default_nettype none

package itp_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
  localparam logic [7:0] CH_LPAREN = 8'h28;  // '('
  localparam logic [7:0] CH_RPAREN = 8'h29;  // ')'
  localparam logic [7:0] CH_LO_A   = 8'h61;  // 'a'
  localparam logic [7:0] CH_LO_Z   = 8'h7A;  // 'z'
  localparam logic [7:0] CH_UP_A   = 8'h41;  // 'A'
  localparam logic [7:0] CH_UP_Z   = 8'h5A;  // 'Z'
  localparam logic [7:0] CH_DIG_0  = 8'h30;  // '0'
  localparam logic [7:0] CH_DIG_9  = 8'h39;  // '9'

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_FLUSH
  } itp_state_e;

  // Shift control shared by every stack cell.
  typedef struct packed {
    logic push;
    logic pop;
  } itp_shift_t;

  function automatic logic [1:0] itp_prio(input logic [7:0] c);
    logic [1:0] p;
    p = 2'd0;
    if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
    if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
    if (c == CH_CARET) p = 2'd3;
    return p;
  endfunction

  function automatic logic itp_is_operand(input logic [7:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
           (c >= CH_DIG_0 && c <= CH_DIG_9);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/itp_cell.sv =====
// One entry of the operator stack. Shifts toward the bottom on push and
// toward the top on pop. Depends on itp_pkg.
`default_nettype none

module itp_cell import itp_pkg::*; (
  input  wire logic       clk_i,
  input  wire itp_shift_t shift_i,
  input  wire logic [7:0] upper_i,
  input  wire logic [7:0] lower_i,
  output logic      [7:0] data_o
);

  logic [7:0] data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i.push) begin
      data_q <= upper_i;
    end else if (shift_i.pop) begin
      data_q <= lower_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/infix_to_postfix_converter_top.sv =====
// Top level: control sequencer, output register and a chain of stack cells.
// Depends on itp_pkg and itp_cell.
`default_nettype none

// Converts infix characters to postfix, one input item at a time. The operator
// stack is a row of STACK_DEPTH cells that shift together; its top sits in the
// first cell. An item is accepted only in idle; then each operator popped to the
// output takes a step, and a final step emits an operand, pushes, or drops the
// matching '('; the last item of an expression then flushes each stack entry
// and ends with the closing item. A stalled output register holds each step
// that loads it. Emission is bounded by one output item per cycle through the
// output register. The final item of each expression carries last_of_expr and
// the overflow flag; an expression with no output gets one item with has_char low.
module infix_to_postfix_converter_top import itp_pkg::*; #(
  parameter int STACK_DEPTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_char_i,
  input  wire logic       end_of_expr_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic      [7:0] out_char_o,
  output logic            has_char_o,
  output logic            last_of_expr_o,
  output logic            stack_overflow_o
);

  localparam int CntW = $clog2(STACK_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(STACK_DEPTH);

  itp_state_e state_q, state_d;

  logic [7:0]      c_q;
  logic            last_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            pend_valid_q, pend_valid_d;
  logic [7:0]      pend_char_q, pend_char_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      out_char_q, out_char_d;
  logic            has_char_q, has_char_d;
  logic            out_last_q, out_last_d;
  logic            out_ovf_q, out_ovf_d;

  logic       in_accept;
  logic       out_free;
  logic       cnt_nz;
  logic       cnt_full;
  logic [7:0] top_char;
  logic       pop_cond;

  logic       emit, emit_ok, emit_fire;
  logic [7:0] emit_char;
  logic       push, pop, step_done, fin;
  logic       out_load;

  itp_shift_t shift;
  logic [7:0] cell_data [STACK_DEPTH];

  // Stack cells
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [7:0] upper, lower;
    if (i == 0) begin : g_first
      assign upper = c_q;
    end else begin : g_mid_up
      assign upper = cell_data[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign lower = cell_data[i];
    end else begin : g_mid_dn
      assign lower = cell_data[i+1];
    end
    itp_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .upper_i (upper),
      .lower_i (lower),
      .data_o  (cell_data[i])
    );
  end

  assign in_accept = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_nz = (cnt_q != '0);
  assign cnt_full = (cnt_q >= CntFull);
  assign top_char = cell_data[0];
  assign pop_cond = (itp_prio(c_q) < itp_prio(top_char)) ||
                    ((itp_prio(c_q) == itp_prio(top_char)) && (c_q != CH_CARET));

  // On the last item each emission is held back one step, so the final one
  // can be marked once the flush is over.
  assign emit_ok = last_q ? (!pend_valid_q || out_free) : out_free;
  assign emit_fire = emit && emit_ok;

  // Control outputs of the sequencer
  always_comb begin
    emit      = 1'b0;
    emit_char = top_char;
    push      = 1'b0;
    pop       = 1'b0;
    step_done = 1'b0;
    fin       = 1'b0;
    case (state_q)
      ST_WORK: begin
        if (itp_is_operand(c_q)) begin
          emit      = 1'b1;
          emit_char = c_q;
          step_done = emit_ok;
        end else if (c_q == CH_LPAREN) begin
          push      = 1'b1;
          step_done = 1'b1;
        end else if (c_q == CH_RPAREN) begin
          if (cnt_nz && top_char != CH_LPAREN) begin
            emit = 1'b1;
            pop  = emit_ok;
          end else begin
            pop       = cnt_nz;  // drop the matching '('
            step_done = 1'b1;
          end
        end else begin
          if (cnt_nz && pop_cond) begin
            emit = 1'b1;
            pop  = emit_ok;
          end else begin
            push      = 1'b1;
            step_done = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (cnt_nz) begin
          emit = 1'b1;
          pop  = emit_ok;
        end else begin
          fin = out_free;
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_WORK;
      ST_WORK:  if (step_done) state_d = last_q ? ST_FLUSH : ST_IDLE;
      ST_FLUSH: if (fin) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign shift.push = push && !cnt_full;
  assign shift.pop  = pop;

  always_comb begin
    cnt_d = cnt_q;
    if (shift.push) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (shift.pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
    ovf_d = ovf_q;
    if (push && cnt_full) ovf_d = 1'b1;
    if (fin) ovf_d = 1'b0;
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_char_d  = pend_char_q;
    if (emit_fire && last_q) begin
      pend_valid_d = 1'b1;
      pend_char_d  = emit_char;
    end
    if (fin) pend_valid_d = 1'b0;
  end

  // Output register load
  always_comb begin
    out_load   = 1'b0;
    out_char_d = out_char_q;
    has_char_d = has_char_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    if (fin) begin
      out_load   = 1'b1;
      out_char_d = pend_valid_q ? pend_char_q : 8'h00;
      has_char_d = pend_valid_q;
      out_last_d = 1'b1;
      out_ovf_d  = ovf_q;
    end else if (emit_fire && !last_q) begin
      out_load   = 1'b1;
      out_char_d = emit_char;
      has_char_d = 1'b1;
      out_last_d = 1'b0;
      out_ovf_d  = 1'b0;
    end else if (emit_fire && pend_valid_q) begin
      out_load   = 1'b1;
      out_char_d = pend_char_q;
      has_char_d = 1'b1;
      out_last_d = 1'b0;
      out_ovf_d  = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      c_q    <= in_char_i;
      last_q <= end_of_expr_i;
    end
    pend_char_q <= pend_char_d;
    out_char_q  <= out_char_d;
    has_char_q  <= has_char_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign out_valid_o      = out_valid_q;
  assign out_char_o       = out_char_q;
  assign has_char_o       = has_char_q;
  assign last_of_expr_o   = out_last_q;
  assign stack_overflow_o = out_ovf_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("stack count above depth");

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pend_valid_q)
    else $error("held item left over in idle");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten while stalled");

  a_fin_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin |=> cnt_q == '0 && !ovf_q && !pend_valid_q)
    else $error("state not cleared at end of expression");

endmodule

`default_nettype wire
